/* rtl/core/uvs_pkg.sv */
`timescale 1ns / 1ps

package uvs_pkg;

	localparam int DEPTH = 16;

	// Field widths of the stream items.
	localparam int CMD_W      = 2;
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 4;
	localparam int STATUS_W   = 3;
	localparam int POSITION_W = 4;
	localparam int COUNT_W    = 5;
	localparam int CAP_W      = 5;

	// Internal widths that follow from the depth.
	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int S_TDATA_W = ((VALUE_W + INDEX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((POSITION_W + VALUE_W + COUNT_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_FIND = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_RANGE    = 3'd5
	} status_t;

	// What each cell hands on to the next one up the chain.
	typedef struct packed {
		logic               hit;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] rdata;
	} chain_t;

endpackage

/* rtl/core/uvs_cell.sv */
`timescale 1ns / 1ps

module uvs_cell import uvs_pkg::*; (
	input  logic               clk,
	input  logic [POS_W-1:0]   cell_pos,
	input  logic [CNT_W-1:0]   count,
	input  logic [VALUE_W-1:0] key,
	input  logic [POS_W-1:0]   rd_index,
	input  logic               push_en,
	input  chain_t             chain_i,
	output chain_t             chain_o
);

	logic [VALUE_W-1:0] entry_q;
	logic               occupied;
	logic               match;

	assign occupied = CNT_W'(cell_pos) < count;
	assign match    = occupied && (entry_q == key);

	// The lowest matching cell claims the position; cells above pass it on.
	always_comb begin
		chain_o.hit   = chain_i.hit | match;
		chain_o.pos   = (match && !chain_i.hit) ? cell_pos : chain_i.pos;
		chain_o.rdata = chain_i.rdata;
		if (occupied && (cell_pos == rd_index)) begin
			chain_o.rdata = chain_i.rdata | entry_q;
		end
	end

	// A successful push writes the cell that sits just above the top.
	always_ff @(posedge clk) begin
		if (push_en && (CNT_W'(cell_pos) == count)) begin
			entry_q <= key;
		end
	end

endmodule

/* rtl/core/unique_value_stack.sv */
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit values that refuses duplicates. Commands arrive on the s_
// stream (push, pop, find, read at index) and each one yields exactly one result item on the
// m_ stream. Every stored value sits in its own cell of a chain of DEPTH cells, the search
// key is compared in all cells at once and the lowest hit ripples up the chain, so a new
// command is taken in every cycle while the output register is free or being emptied. The
// capacity register may only be written while the block is idle; entries already stored
// are kept when it is lowered.
module unique_value_stack import uvs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // value [31:0], index [35:32]
	input  logic [CMD_W-1:0]     s_tuser,   // cmd [1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // position [3:0], read_value [35:4], count [40:36]
	output logic [STATUS_W-1:0]  m_tuser    // status [2:0]
);

	logic [CAP_W-1:0]      cap_q;
	logic [CNT_W-1:0]      count_q;
	logic                  m_valid_q;
	status_t               status_q;
	logic [POSITION_W-1:0] position_q;
	logic [VALUE_W-1:0]    read_value_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic                  accept;
	cmd_t                  cmd;
	logic [VALUE_W-1:0]    value;
	logic [INDEX_W-1:0]    index;
	logic                  full;
	logic                  push_en;
	status_t               status_d;
	logic [POSITION_W-1:0] position_d;
	logic [VALUE_W-1:0]    read_value_d;
	logic [CNT_W-1:0]      count_d;
	chain_t                chain [DEPTH+1];

	assign cmd    = cmd_t'(s_tuser);
	assign value  = s_tdata[VALUE_W-1:0];
	assign index  = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign chain[0] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		uvs_cell u_cell (
			.clk      (clk),
			.cell_pos (POS_W'(g)),
			.count    (count_q),
			.key      (value),
			.rd_index (POS_W'(index)),
			.push_en  (push_en),
			.chain_i  (chain[g]),
			.chain_o  (chain[g+1])
		);
	end

	assign full = (int'(count_q) >= int'(cap_q)) || (int'(count_q) >= DEPTH);

	always_comb begin
		status_d     = ST_OK;
		position_d   = '0;
		read_value_d = '0;
		count_d      = count_q;
		push_en      = 1'b0;
		unique case (cmd)
			CMD_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (chain[DEPTH].hit) begin
					status_d = ST_DUP;
				end else begin
					push_en = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_FIND: begin
				if (chain[DEPTH].hit) begin
					position_d = POSITION_W'(chain[DEPTH].pos);
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			CMD_READ: begin
				if (int'(index) < int'(count_q)) begin
					read_value_d = chain[DEPTH].rdata;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			position_q   <= position_d;
			read_value_q <= read_value_d;
			count_out_q  <= COUNT_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({count_out_q, read_value_q, position_q});

endmodule

/* rtl/core/uvs_checker.sv */
`timescale 1ns / 1ps

module uvs_checker import uvs_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]  m_tuser
);

	// The input side only stalls while a result item is held back.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a waiting result item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result item changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tdata[40:36] == 5'd0))
		else $error("empty status with a non-zero count");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= ST_RANGE) && (int'(m_tdata[40:36]) <= DEPTH))
		else $error("result item out of its legal range");

endmodule

bind unique_value_stack uvs_checker u_uvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* dv/unique_value_stack_tb.sv */
`timescale 1ns / 1ps

module unique_value_stack_tb;
	import uvs_pkg::*;

	localparam int HOLD_CYCLES = 40;
	localparam int PHASE_ITEMS = 205;

	typedef struct packed {
		status_t               st;
		logic [POSITION_W-1:0] pos;
		logic [VALUE_W-1:0]    rd;
		logic [COUNT_W-1:0]    cnt;
	} answer_t;

	// One line of the directed script: either a capacity write or a command.
	typedef struct packed {
		logic                 is_cfg;
		logic [CAP_W-1:0]     cap;
		cmd_t                 op;
		logic [VALUE_W-1:0]   val;
		logic [INDEX_W-1:0]   idx;
		logic                 typed;
		status_t              st;
		logic [COUNT_W-1:0]   cnt;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = CMD_PUSH;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// Shadow copy of the stack and its capacity register.
	logic [VALUE_W-1:0] shadow_mem [DEPTH];
	logic [COUNT_W-1:0] shadow_fill = '0;
	logic [CAP_W-1:0]   shadow_cap = CAP_RESET;

	answer_t      pending_answers [$];
	script_row_t  script [$];
	int           fails = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_req = 0;

	unique_value_stack DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic answer_t next_answer(cmd_t op, logic [VALUE_W-1:0] v,
			logic [INDEX_W-1:0] idx);
		answer_t a;
		int      hit;
		int      lim;
		a = '0;
		a.st = ST_OK;
		lim = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
		hit = -1;
		for (int i = 0; i < shadow_fill; i++) begin
			if (hit < 0 && shadow_mem[i] == v)
				hit = i;
		end
		case (op)
			CMD_PUSH: begin
				// The full test takes precedence over the duplicate test.
				if (shadow_fill >= lim)
					a.st = ST_FULL;
				else if (hit >= 0)
					a.st = ST_DUP;
				else begin
					shadow_mem[shadow_fill] = v;
					shadow_fill = shadow_fill + 1'b1;
				end
			end
			CMD_POP: begin
				if (shadow_fill == 0)
					a.st = ST_EMPTY;
				else
					shadow_fill = shadow_fill - 1'b1;
			end
			CMD_FIND: begin
				if (hit < 0)
					a.st = ST_NOTFOUND;
				else
					a.pos = POSITION_W'(hit);
			end
			default: begin
				if (idx < shadow_fill)
					a.rd = shadow_mem[idx];
				else
					a.st = ST_RANGE;
			end
		endcase
		a.cnt = shadow_fill;
		return a;
	endfunction

	function automatic void add_cmd(cmd_t op, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
		script_row_t r;
		r = '0;
		r.op = op;
		r.val = v;
		r.idx = idx;
		script.push_back(r);
	endfunction

	function automatic void add_checked(cmd_t op, logic [VALUE_W-1:0] v,
			logic [INDEX_W-1:0] idx, status_t st, logic [COUNT_W-1:0] cnt);
		script_row_t r;
		r = '0;
		r.op = op;
		r.val = v;
		r.idx = idx;
		r.typed = 1'b1;
		r.st = st;
		r.cnt = cnt;
		script.push_back(r);
	endfunction

	function automatic void add_cap(logic [CAP_W-1:0] cap);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cap = cap;
		script.push_back(r);
	endfunction

	// Offers one item, waits for it to be taken and records its expected answer.
	task automatic issue(cmd_t op, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx,
			logic typed, status_t st, logic [COUNT_W-1:0] cnt);
		answer_t a;
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({idx, v});
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		a = next_answer(op, v, idx);
		if (typed) begin
			a = '0;
			a.st = st;
			a.cnt = cnt;
		end
		pending_answers.push_back(a);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] cap);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		shadow_cap = cap;
		cfg_we <= 1'b0;
	endtask

	// Result side: checks every item taken and decides the next stall.
	initial begin
		int      hold_seen;
		int      hold_left;
		answer_t e;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_answers.size() == 0) begin
					$error("result item with no command outstanding");
					fails++;
				end else begin
					e = pending_answers.pop_front();
					if (m_tuser !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, m_tuser);
						fails++;
					end
					if (m_tdata[POSITION_W-1:0] !== e.pos) begin
						$error("position: expected %0d, got %0d", e.pos,
							m_tdata[POSITION_W-1:0]);
						fails++;
					end
					if (m_tdata[POSITION_W +: VALUE_W] !== e.rd) begin
						$error("read_value: expected %h, got %h", e.rd,
							m_tdata[POSITION_W +: VALUE_W]);
						fails++;
					end
					if (m_tdata[POSITION_W + VALUE_W +: COUNT_W] !== e.cnt) begin
						$error("count: expected %0d, got %0d", e.cnt,
							m_tdata[POSITION_W + VALUE_W +: COUNT_W]);
						fails++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int                 ph;
		int                 n;
		int                 r;
		int                 push_pct;
		logic [CAP_W-1:0]   caps [8];
		logic [VALUE_W-1:0] pool [8];
		logic [VALUE_W-1:0] v;
		logic [INDEX_W-1:0] idx;

		// Empty stack at reset, with the reset capacity.
		add_checked(CMD_POP,  32'h0, 4'd0, ST_EMPTY, 5'd0);
		add_checked(CMD_FIND, 32'h0, 4'd0, ST_NOTFOUND, 5'd0);
		add_checked(CMD_READ, 32'h0, 4'd0, ST_RANGE, 5'd0);
		add_checked(CMD_READ, 32'hFFFFFFFF, 4'd15, ST_RANGE, 5'd0);
		add_checked(CMD_PUSH, 32'h80000000, 4'd0, ST_OK, 5'd1);
		add_checked(CMD_PUSH, 32'h7FFFFFFF, 4'd0, ST_OK, 5'd2);
		add_checked(CMD_PUSH, 32'h00000000, 4'd0, ST_OK, 5'd3);
		add_checked(CMD_PUSH, 32'hFFFFFFFF, 4'd0, ST_OK, 5'd4);
		add_checked(CMD_PUSH, 32'h80000000, 4'd0, ST_DUP, 5'd4);
		add_cmd(CMD_FIND, 32'h7FFFFFFF, 4'd0);
		add_cmd(CMD_FIND, 32'hFFFFFFFF, 4'd0);
		add_checked(CMD_FIND, 32'h12345678, 4'd0, ST_NOTFOUND, 5'd4);
		add_cmd(CMD_READ, 32'h0, 4'd0);
		add_cmd(CMD_READ, 32'h0, 4'd3);
		add_checked(CMD_READ, 32'h0, 4'd4, ST_RANGE, 5'd4);
		add_checked(CMD_POP, 32'h0, 4'd0, ST_OK, 5'd3);
		add_cmd(CMD_FIND, 32'hFFFFFFFF, 4'd0);
		add_cmd(CMD_PUSH, 32'hFFFFFFFF, 4'd0);
		// A full stack answers full even for a value it already holds.
		add_cap(5'd4);
		add_checked(CMD_PUSH, 32'd99, 4'd0, ST_FULL, 5'd4);
		add_checked(CMD_PUSH, 32'h0, 4'd0, ST_FULL, 5'd4);
		// Capacity below the fill keeps the entries; pops must bring it down first.
		add_cap(5'd2);
		add_checked(CMD_PUSH, 32'd5, 4'd0, ST_FULL, 5'd4);
		add_checked(CMD_POP, 32'h0, 4'd0, ST_OK, 5'd3);
		add_checked(CMD_POP, 32'h0, 4'd0, ST_OK, 5'd2);
		add_checked(CMD_PUSH, 32'd5, 4'd0, ST_FULL, 5'd2);
		add_checked(CMD_POP, 32'h0, 4'd0, ST_OK, 5'd1);
		add_cmd(CMD_PUSH, 32'd5, 4'd0);
		add_cap(5'd0);
		add_checked(CMD_PUSH, 32'd6, 4'd0, ST_FULL, 5'd2);
		add_cap(5'd31);
		add_cmd(CMD_PUSH, 32'd6, 4'd0);

		caps[0] = 5'd16;
		caps[1] = 5'd1;
		caps[2] = 5'd31;
		caps[3] = 5'd0;
		caps[4] = 5'd5;
		caps[5] = 5'd16;
		caps[6] = CAP_W'($urandom_range(2, 15));
		caps[7] = 5'd16;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				set_capacity(script[i].cap);
			else
				issue(script[i].op, script[i].val, script[i].idx, script[i].typed,
					script[i].st, script[i].cnt);
		end

		// Long receiver hold-off while items keep coming, so the input backs up.
		hold_req <= hold_req + 1;
		for (n = 0; n < 30; n++)
			issue(n[0] ? CMD_FIND : CMD_PUSH, 32'(n % 7), INDEX_W'(n), 1'b0, ST_OK, '0);
		drain_results();

		for (ph = 0; ph < 8; ph++) begin
			set_capacity(caps[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			push_pct = ph[0] ? 30 : 45;
			// A small pool of values makes duplicates and finds hit often.
			pool[0] = 32'h80000000;
			pool[1] = 32'h7FFFFFFF;
			for (n = 2; n < 8; n++)
				pool[n] = $urandom;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				v = $urandom;
				idx = INDEX_W'($urandom_range(15));
				if (r < push_pct) begin
					if ($urandom_range(1) != 0)
						v = pool[$urandom_range(7)];
					issue(CMD_PUSH, v, idx, 1'b0, ST_OK, '0);
				end else if (r < push_pct + 20)
					issue(CMD_POP, v, idx, 1'b0, ST_OK, '0);
				else if ($urandom_range(1) != 0) begin
					if (shadow_fill != 0 && $urandom_range(2) != 0)
						v = shadow_mem[$urandom_range(shadow_fill - 1)];
					else if ($urandom_range(1) != 0)
						v = pool[$urandom_range(7)];
					issue(CMD_FIND, v, idx, 1'b0, ST_OK, '0);
				end else begin
					if (shadow_fill != 0 && $urandom_range(1) != 0)
						idx = INDEX_W'($urandom_range(shadow_fill - 1));
					issue(CMD_READ, v, idx, 1'b0, ST_OK, '0);
				end
				if ($urandom_range(49) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fails == 0 && pending_answers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/uvs_pkg.sv
rtl/core/uvs_cell.sv
rtl/core/unique_value_stack.sv
rtl/core/uvs_checker.sv
dv/unique_value_stack_tb.sv
